// File: rtl/msi_pkg.sv
// Shared types, codes and helpers for the motion safety interlock.
`timescale 1ns / 1ps

package msi_pkg;

  // Block constants
  localparam int          PERIOD_MS_DEF   = 20;
  localparam int          RANGE_COUNT     = 4;
  localparam int          NUM_RANGES      = 4;
  localparam logic [15:0] RANGE_FLOOR_MM  = 16'd10;
  localparam logic [15:0] MIN_DURATION_MS = 16'd100;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;

  // Event codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_RANGES     = 3'd1,
    MODE_STATUS     = 3'd2,
    MODE_ARM        = 3'd3,
    MODE_COMMAND    = 3'd4,
    MODE_DISCONNECT = 3'd5
  } mode_e;

  // Motion command codes
  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_IDLE     = 3'd1,
    CMD_FORWARD  = 3'd2,
    CMD_BACKWARD = 3'd3,
    CMD_LEFT     = 3'd4,
    CMD_RIGHT    = 3'd5
  } cmd_e;

  // Result detail codes
  typedef enum logic [3:0] {
    DET_READY       = 4'd0,
    DET_STALE       = 4'd1,
    DET_OBST_UNKN   = 4'd2,
    DET_OBSTACLE    = 4'd3,
    DET_LATCHED     = 4'd4,
    DET_ARMED       = 4'd5,
    DET_STOPPED     = 4'd6,
    DET_IDLE        = 4'd7,
    DET_ACCEPTED    = 4'd8,
    DET_ZERO        = 4'd9,
    DET_NOT_CLEAR   = 4'd10,
    DET_UNSUPPORTED = 4'd11
  } detail_e;

  // Drive request kinds
  typedef enum logic [1:0] {
    DRIVE_NONE = 2'd0,
    DRIVE_STOP = 2'd1,
    DRIVE_MOVE = 2'd2
  } drive_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_OBSTACLE_STOP = 3'd0,
    CFG_MAX_LINEAR    = 3'd1,
    CFG_MAX_TURN      = 3'd2,
    CFG_MAX_DURATION  = 3'd3,
    CFG_STATE_TIMEOUT = 3'd4,
    CFG_NEED_STATE    = 3'd5,
    CFG_NEED_CLEAR    = 3'd6
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [15:0] obstacle_stop_mm;
    logic [14:0] max_linear_speed;
    logic [14:0] max_turn_rate;
    logic [15:0] max_duration_ms;
    logic [15:0] stale_after_ms;
    logic        need_robot_state;
    logic        need_clear_path;
  } msi_cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         command_code;
    logic               emergency_flag;
    logic signed [15:0] linear_request;
    logic signed [15:0] turn_request;
    logic signed [15:0] duration_request;
    logic [15:0]        range_a;
    logic [15:0]        range_b;
    logic [15:0]        range_c;
    logic [15:0]        range_d;
    logic [3:0]         range_valid;
  } msi_in_t;

  typedef struct packed {
    logic               ok;
    logic [3:0]         detail_code;
    logic               connected;
    logic               obstacle_valid;
    logic               obstacle_seen;
    logic               estop_active;
    logic [15:0]        nearest_mm;
    logic [1:0]         drive_kind;
    logic signed [15:0] drive_linear;
    logic signed [15:0] drive_turn;
  } msi_out_t;

  // Robot state counts as fresh while seen, not saturated and within timeout
  function automatic logic is_fresh(input logic seen, input logic [15:0] age,
                                    input logic [15:0] timeout);
    return seen && (age != AGE_MAX) && (age <= timeout);
  endfunction

endpackage

// File: rtl/msi_if.sv
// Valid/ready channel interfaces for event items and result items.
`timescale 1ns / 1ps

interface msi_in_if;
  logic             valid;
  logic             ready;
  msi_pkg::msi_in_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface msi_out_if;
  logic              valid;
  logic              ready;
  msi_pkg::msi_out_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/msi_core.sv
// Interlock state and per-event decision logic, one event per step.
`timescale 1ns / 1ps

module msi_core #(
  parameter int PERIOD_MS = msi_pkg::PERIOD_MS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msi_pkg::msi_cfg_t cfg_i,
  input  msi_pkg::msi_in_t  item_i,
  input  logic              step_i,
  output msi_pkg::msi_out_t result_o
);
  import msi_pkg::*;

  localparam int PW = $clog2(PERIOD_MS + 1);

  // Interlock state
  logic          seen_q, seen_d;
  logic          known_q, known_d;
  logic          flag_q, flag_d;
  logic [15:0]   nearest_q, nearest_d;
  logic [15:0]   age_q, age_d;
  logic          latch_q, latch_d;
  logic          stop_sent_q, stop_sent_d;
  logic [15:0]   lin_q, lin_d;
  logic [15:0]   turn_q, turn_d;
  logic [15:0]   tl_q, tl_d;
  logic [PW-1:0] period_q, period_d;

  // Values shared by several events
  logic [15:0]   age_inc, age_mid, tl_dec;
  logic [PW-1:0] period_inc;
  logic          fresh_mid, conn_mid, clear_mid;

  // Range filtering
  logic [15:0]           rng [NUM_RANGES];
  logic [NUM_RANGES-1:0] rng_use;
  logic                  rng_any, rng_near;
  logic [15:0]           rng_least;

  // Command shaping
  logic [15:0] lin_raw, turn_raw, lin_mag, turn_mag, dur_lo, dur;
  logic [14:0] lin_clamp, turn_clamp, lin_sel, turn_sel;
  logic        is_linear;

  // Result fields
  logic        ok, use_status, halt_req, fresh_post, conn_post, valid_post;
  logic [3:0]  detail;
  logic [1:0]  kind;
  logic [15:0] dlin, dturn;

  assign age_inc    = (seen_q && age_q != AGE_MAX) ? age_q + 16'd1 : age_q;
  assign age_mid    = (item_i.mode == MODE_TICK) ? age_inc : age_q;
  assign tl_dec     = (tl_q != 16'd0) ? tl_q - 16'd1 : tl_q;
  assign period_inc = period_q + PW'(1);
  assign fresh_mid  = is_fresh(seen_q, age_mid, cfg_i.stale_after_ms);
  assign conn_mid   = !cfg_i.need_robot_state || fresh_mid;
  assign clear_mid  = !cfg_i.need_clear_path || (fresh_mid && known_q && !flag_q);

  // Filter the ranges and find the nearest usable one
  assign rng[0] = item_i.range_a;
  assign rng[1] = item_i.range_b;
  assign rng[2] = item_i.range_c;
  assign rng[3] = item_i.range_d;

  always_comb begin
    rng_any   = 1'b0;
    rng_near  = 1'b0;
    rng_least = AGE_MAX;
    for (int i = 0; i < NUM_RANGES; i++) begin
      rng_use[i] = (i < RANGE_COUNT) && item_i.range_valid[i] && (rng[i] > RANGE_FLOOR_MM);
      if (rng_use[i]) begin
        rng_any = 1'b1;
        if (rng[i] < rng_least) rng_least = rng[i];
        if (rng[i] <= cfg_i.obstacle_stop_mm) rng_near = 1'b1;
      end
    end
  end

  // Clamp requested speeds by magnitude and the duration to its bounds
  assign lin_raw    = $unsigned(item_i.linear_request);
  assign turn_raw   = $unsigned(item_i.turn_request);
  assign lin_mag    = lin_raw[15] ? (~lin_raw + 16'd1) : lin_raw;
  assign turn_mag   = turn_raw[15] ? (~turn_raw + 16'd1) : turn_raw;
  assign lin_clamp  = (lin_mag > {1'b0, cfg_i.max_linear_speed}) ?
                      cfg_i.max_linear_speed : lin_mag[14:0];
  assign turn_clamp = (turn_mag > {1'b0, cfg_i.max_turn_rate}) ?
                      cfg_i.max_turn_rate : turn_mag[14:0];
  assign is_linear  = (item_i.command_code == CMD_FORWARD) ||
                      (item_i.command_code == CMD_BACKWARD);
  assign lin_sel    = is_linear ? lin_clamp : 15'd0;
  assign turn_sel   = is_linear ? 15'd0 : turn_clamp;
  assign dur_lo     = (item_i.duration_request < $signed(MIN_DURATION_MS)) ?
                      MIN_DURATION_MS : $unsigned(item_i.duration_request);
  assign dur        = (dur_lo > cfg_i.max_duration_ms) ? cfg_i.max_duration_ms : dur_lo;

  // Decide the event and the next state
  always_comb begin
    seen_d      = seen_q;
    known_d     = known_q;
    flag_d      = flag_q;
    nearest_d   = nearest_q;
    age_d       = age_q;
    latch_d     = latch_q;
    stop_sent_d = stop_sent_q;
    lin_d       = lin_q;
    turn_d      = turn_q;
    tl_d        = tl_q;
    period_d    = period_q;
    ok          = 1'b1;
    detail      = DET_READY;
    use_status  = 1'b0;
    halt_req    = 1'b0;
    kind        = DRIVE_NONE;
    dlin        = 16'd0;
    dturn       = 16'd0;

    unique case (item_i.mode)
      MODE_TICK: begin
        use_status = 1'b1;
        age_d      = age_inc;
        tl_d       = tl_dec;
        if (period_inc >= PW'(PERIOD_MS)) begin
          period_d = '0;
          halt_req = latch_q || (tl_dec == 16'd0) || !conn_mid || !clear_mid ||
                     (lin_q == 16'd0 && turn_q == 16'd0);
          if (halt_req) begin
            lin_d  = 16'd0;
            turn_d = 16'd0;
            // send one stop, then stay quiet until an event clears stop_sent
            if (!stop_sent_q) begin
              stop_sent_d = 1'b1;
              kind        = DRIVE_STOP;
            end
          end else begin
            stop_sent_d = 1'b0;
            kind        = DRIVE_MOVE;
            dlin        = lin_q;
            dturn       = turn_q;
          end
        end else begin
          period_d = period_inc;
        end
      end
      MODE_RANGES: begin
        use_status = 1'b1;
        seen_d     = 1'b1;
        known_d    = rng_any;
        flag_d     = rng_near;
        nearest_d  = rng_any ? rng_least : 16'd0;
        age_d      = 16'd0;
      end
      MODE_STATUS: begin
        use_status = 1'b1;
      end
      MODE_ARM: begin
        if (!conn_mid) begin
          ok     = 1'b0;
          detail = DET_STALE;
        end else if (!clear_mid) begin
          ok     = 1'b0;
          detail = DET_NOT_CLEAR;
        end else begin
          latch_d     = 1'b0;
          lin_d       = 16'd0;
          turn_d      = 16'd0;
          stop_sent_d = 1'b0;
          detail      = DET_ARMED;
        end
      end
      MODE_COMMAND: begin
        if (item_i.emergency_flag || item_i.command_code == CMD_STOP) begin
          lin_d       = 16'd0;
          turn_d      = 16'd0;
          stop_sent_d = 1'b0;
          if (item_i.emergency_flag) latch_d = 1'b1;
          detail      = item_i.emergency_flag ? DET_LATCHED : DET_STOPPED;
        end else begin
          case (item_i.command_code) inside
            CMD_IDLE: begin
              lin_d       = 16'd0;
              turn_d      = 16'd0;
              stop_sent_d = 1'b0;
              detail      = DET_IDLE;
            end
            CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT: begin
              if (lin_sel == 15'd0 && turn_sel == 15'd0) begin
                ok     = 1'b0;
                detail = DET_ZERO;
              end else if (latch_q) begin
                ok     = 1'b0;
                detail = DET_LATCHED;
              end else if (!conn_mid) begin
                ok     = 1'b0;
                detail = DET_STALE;
              end else if (!clear_mid) begin
                ok          = 1'b0;
                detail      = DET_NOT_CLEAR;
                lin_d       = 16'd0;
                turn_d      = 16'd0;
                stop_sent_d = 1'b0;
              end else begin
                lin_d       = (item_i.command_code == CMD_BACKWARD) ?
                              16'd0 - {1'b0, lin_sel} : {1'b0, lin_sel};
                turn_d      = (item_i.command_code == CMD_RIGHT) ?
                              16'd0 - {1'b0, turn_sel} : {1'b0, turn_sel};
                tl_d        = dur;
                stop_sent_d = 1'b0;
                detail      = DET_ACCEPTED;
              end
            end
            default: begin
              ok     = 1'b0;
              detail = DET_UNSUPPORTED;
            end
          endcase
        end
      end
      MODE_DISCONNECT: begin
        use_status  = 1'b1;
        lin_d       = 16'd0;
        turn_d      = 16'd0;
        stop_sent_d = 1'b0;
      end
      default: begin
        ok     = 1'b0;
        detail = DET_UNSUPPORTED;
      end
    endcase

    // Status after the event has been applied
    fresh_post = is_fresh(seen_d, age_d, cfg_i.stale_after_ms);
    conn_post  = !cfg_i.need_robot_state || fresh_post;
    valid_post = known_d && fresh_post;
    if (use_status) begin
      if (!conn_post)                                              detail = DET_STALE;
      else if (cfg_i.need_clear_path && (!known_d || !fresh_post)) detail = DET_OBST_UNKN;
      else if (flag_d)                                             detail = DET_OBSTACLE;
      else if (latch_d)                                            detail = DET_LATCHED;
      else                                                         detail = DET_READY;
    end

    result_o.ok             = ok;
    result_o.detail_code    = detail;
    result_o.connected      = conn_post;
    result_o.obstacle_valid = valid_post;
    result_o.obstacle_seen  = valid_post && flag_d;
    result_o.estop_active   = latch_d;
    result_o.nearest_mm     = valid_post ? nearest_d : 16'd0;
    result_o.drive_kind     = kind;
    result_o.drive_linear   = $signed(dlin);
    result_o.drive_turn     = $signed(dturn);
  end

  // Advance the state on each event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      known_q     <= 1'b0;
      flag_q      <= 1'b0;
      nearest_q   <= 16'd0;
      age_q       <= 16'd0;
      latch_q     <= 1'b1;
      stop_sent_q <= 1'b0;
      lin_q       <= 16'd0;
      turn_q      <= 16'd0;
      tl_q        <= 16'd0;
      period_q    <= '0;
    end else if (step_i) begin
      seen_q      <= seen_d;
      known_q     <= known_d;
      flag_q      <= flag_d;
      nearest_q   <= nearest_d;
      age_q       <= age_d;
      latch_q     <= latch_d;
      stop_sent_q <= stop_sent_d;
      lin_q       <= lin_d;
      turn_q      <= turn_d;
      tl_q        <= tl_d;
      period_q    <= period_d;
    end
  end

  // A move is only issued while the emergency latch is clear
  a_move_unlatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.drive_kind == DRIVE_MOVE |-> !latch_q)
    else $error("move issued while latched");

  // The period counter wraps before reaching the period
  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q < PW'(PERIOD_MS))
    else $error("period counter out of range");

  // A stop request marks the stop as sent
  a_stop_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.drive_kind == DRIVE_STOP |=> stop_sent_q)
    else $error("stop sent flag not set");

endmodule

// File: rtl/motion_safety_interlock_unit.sv
// Top level of the motion safety interlock: channels, configuration, staging.
`timescale 1ns / 1ps

// Usage:
// Events arrive on in_i (tick, obstacle ranges, status, arm, command,
// disconnect); each one gives exactly one result item on out_o.
// An event is taken into an input register, decided against the interlock
// state once the output register is free or draining, and its result lands
// in an output register. Throughput is one event per cycle while the
// receiver takes every result.
// When the receiver stalls, the result holds in the output register and one
// more event may wait in the input register; in_i.ready then drops.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must do this only while no event is in flight, which the block does
// not enforce; unknown indexes are ignored. After reset the emergency latch
// is set, robot state is unseen, no motion is held and the registers take
// their default limits; an arm event with fresh state and a clear path
// releases the latch. Every PERIOD_MS tick events one drive decision is made:
// a move, or one stop that is not repeated until an event clears stop_sent.

module motion_safety_interlock_unit #(
  parameter int PERIOD_MS = msi_pkg::PERIOD_MS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  msi_in_if.sink                          in_i,
  msi_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [msi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import msi_pkg::*;

  msi_cfg_t cfg_q;
  logic     in_valid_q;
  msi_in_t  in_item_q;
  logic     out_valid_q;
  msi_out_t out_item_q;
  msi_out_t result;
  logic     fire;

  // Decide the held event when the output register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obstacle_stop_mm <= 16'd450;
      cfg_q.max_linear_speed <= 15'd500;
      cfg_q.max_turn_rate    <= 15'd1000;
      cfg_q.max_duration_ms  <= 16'd2000;
      cfg_q.stale_after_ms   <= 16'd1000;
      cfg_q.need_robot_state <= 1'b1;
      cfg_q.need_clear_path  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OBSTACLE_STOP: cfg_q.obstacle_stop_mm <= cfg_data_i;
        CFG_MAX_LINEAR:    cfg_q.max_linear_speed <= cfg_data_i[14:0];
        CFG_MAX_TURN:      cfg_q.max_turn_rate    <= cfg_data_i[14:0];
        CFG_MAX_DURATION:  cfg_q.max_duration_ms  <= cfg_data_i;
        CFG_STATE_TIMEOUT: cfg_q.stale_after_ms   <= cfg_data_i;
        CFG_NEED_STATE:    cfg_q.need_robot_state <= cfg_data_i[0];
        CFG_NEED_CLEAR:    cfg_q.need_clear_path  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register: take an item whenever the slot is free or emptying
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_item_q <= in_i.item;
  end

  msi_core #(
    .PERIOD_MS (PERIOD_MS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (in_item_q),
    .step_i   (fire),
    .result_o (result)
  );

  // Output register: load on a decision, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_item_q <= result;
  end

  // A decided event always leaves a result behind
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("decided item left no result");

  // A held event that was not decided stays unchanged
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_item_q))
    else $error("held item lost or changed");

  // An empty input register never refuses an item
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input refused while empty");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the motion safety interlock: random events, live prediction.
`timescale 1ns / 1ps

module tb_top;
  import msi_pkg::*;

  // Codes outside the named mode and command sets
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [2:0] CMD_SPARE_A  = 3'd6;
  localparam logic [2:0] CMD_SPARE_B  = 3'd7;

  localparam logic [15:0] EDGE_SPEEDS [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                              16'h8000};

  // Tracks interlock state, predicts each result item and checks the block's output
  class interlock_tracker;
    logic [15:0] stop_mm;
    logic [14:0] lin_max;
    logic [14:0] turn_max;
    logic [15:0] dur_max;
    logic [15:0] age_limit;
    logic        need_state;
    logic        need_clear;
    logic        seen;
    logic        obst_known;
    logic        obst_flag;
    logic        latched;
    logic        stop_sent;
    logic [15:0] nearest;
    logic [15:0] age;
    logic [15:0] mot_lin;
    logic [15:0] mot_turn;
    logic [15:0] time_left;
    logic [4:0]  tick_count;
    int unsigned period;
    int unsigned mismatches;
    msi_out_t    pending_results[$];

    function new(int unsigned period_ms);
      period     = period_ms;
      stop_mm    = 16'd450;
      lin_max    = 15'd500;
      turn_max   = 15'd1000;
      dur_max    = 16'd2000;
      age_limit  = 16'd1000;
      need_state = 1'b1;
      need_clear = 1'b1;
      seen       = 1'b0;
      obst_known = 1'b0;
      obst_flag  = 1'b0;
      latched    = 1'b1;
      stop_sent  = 1'b0;
      nearest    = '0;
      age        = '0;
      mot_lin    = '0;
      mot_turn   = '0;
      time_left  = '0;
      tick_count = '0;
      mismatches = 0;
    endfunction

    function void set_limit(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CFG_OBSTACLE_STOP: stop_mm    = data;
        CFG_MAX_LINEAR:    lin_max    = data[14:0];
        CFG_MAX_TURN:      turn_max   = data[14:0];
        CFG_MAX_DURATION:  dur_max    = data;
        CFG_STATE_TIMEOUT: age_limit  = data;
        CFG_NEED_STATE:    need_state = data[0];
        CFG_NEED_CLEAR:    need_clear = data[0];
        default: ;
      endcase
    endfunction

    function logic fresh();
      return seen && (age != 16'hFFFF) && (age <= age_limit);
    endfunction

    function logic connected();
      return !need_state || fresh();
    endfunction

    function logic clear_path();
      return !need_clear || (fresh() && obst_known && !obst_flag);
    endfunction

    function detail_e status_code();
      if (!connected()) return DET_STALE;
      if (need_clear && (!obst_known || !fresh())) return DET_OBST_UNKN;
      if (obst_flag) return DET_OBSTACLE;
      if (latched) return DET_LATCHED;
      return DET_READY;
    endfunction

    function logic [15:0] magnitude(logic [15:0] raw);
      return raw[15] ? 16'(17'h10000 - raw) : raw;
    endfunction

    function void drop_motion();
      mot_lin   = '0;
      mot_turn  = '0;
      stop_sent = 1'b0;
    endfunction

    // Advance the state by one accepted event item and queue the result it causes
    function void note_event(msi_in_t ev);
      msi_out_t    res;
      logic [15:0] readings [4];
      logic [15:0] least;
      logic [15:0] lin;
      logic [15:0] turn;
      logic        any_known;
      logic        any_seen;
      logic        obs_ok;
      int          dur;
      res    = '0;
      res.ok = 1'b1;
      case (ev.mode)
        MODE_TICK: begin
          if (seen && age != 16'hFFFF) age++;
          if (time_left != 0) time_left--;
          tick_count++;
          if (tick_count >= period) begin
            tick_count = '0;
            if (latched || time_left == 0 || !connected() || !clear_path() ||
                (mot_lin == 0 && mot_turn == 0)) begin
              mot_lin  = '0;
              mot_turn = '0;
              if (!stop_sent) begin
                stop_sent      = 1'b1;
                res.drive_kind = DRIVE_STOP;
              end
            end else begin
              stop_sent        = 1'b0;
              res.drive_kind   = DRIVE_MOVE;
              res.drive_linear = mot_lin;
              res.drive_turn   = mot_turn;
            end
          end
          res.detail_code = status_code();
        end
        MODE_RANGES: begin
          readings  = '{ev.range_a, ev.range_b, ev.range_c, ev.range_d};
          least     = 16'hFFFF;
          any_known = 1'b0;
          any_seen  = 1'b0;
          // skip unflagged readings and anything at or under the floor
          for (int i = 0; i < RANGE_COUNT && i < NUM_RANGES; i++) begin
            if (ev.range_valid[i] && readings[i] > RANGE_FLOOR_MM) begin
              any_known = 1'b1;
              if (readings[i] < least) least = readings[i];
              if (readings[i] <= stop_mm) any_seen = 1'b1;
            end
          end
          seen            = 1'b1;
          obst_known      = any_known;
          obst_flag       = any_seen;
          nearest         = any_known ? least : 16'd0;
          age             = '0;
          res.detail_code = status_code();
        end
        MODE_STATUS: res.detail_code = status_code();
        MODE_ARM: begin
          if (!connected()) begin
            res.ok          = 1'b0;
            res.detail_code = DET_STALE;
          end else if (!clear_path()) begin
            res.ok          = 1'b0;
            res.detail_code = DET_NOT_CLEAR;
          end else begin
            latched = 1'b0;
            drop_motion();
            res.detail_code = DET_ARMED;
          end
        end
        MODE_COMMAND: begin
          if (ev.command_code == CMD_STOP || ev.emergency_flag) begin
            drop_motion();
            if (ev.emergency_flag) latched = 1'b1;
            res.detail_code = ev.emergency_flag ? DET_LATCHED : DET_STOPPED;
          end else if (ev.command_code == CMD_IDLE) begin
            drop_motion();
            res.detail_code = DET_IDLE;
          end else if (ev.command_code > CMD_RIGHT) begin
            res.ok          = 1'b0;
            res.detail_code = DET_UNSUPPORTED;
          end else begin
            lin  = '0;
            turn = '0;
            if (ev.command_code == CMD_FORWARD || ev.command_code == CMD_BACKWARD) begin
              lin = magnitude(ev.linear_request);
              if (lin > {1'b0, lin_max}) lin = {1'b0, lin_max};
            end else begin
              turn = magnitude(ev.turn_request);
              if (turn > {1'b0, turn_max}) turn = {1'b0, turn_max};
            end
            // raise to the floor first, then the register ceiling wins
            dur = $signed(ev.duration_request);
            if (dur < int'(MIN_DURATION_MS)) dur = int'(MIN_DURATION_MS);
            if (dur > int'(dur_max)) dur = int'(dur_max);
            if (lin == 0 && turn == 0) begin
              res.ok          = 1'b0;
              res.detail_code = DET_ZERO;
            end else if (latched) begin
              res.ok          = 1'b0;
              res.detail_code = DET_LATCHED;
            end else if (!connected()) begin
              res.ok          = 1'b0;
              res.detail_code = DET_STALE;
            end else if (!clear_path()) begin
              res.ok          = 1'b0;
              res.detail_code = DET_NOT_CLEAR;
              drop_motion();
            end else begin
              mot_lin         = (ev.command_code == CMD_BACKWARD) ? 16'(0 - lin) : lin;
              mot_turn        = (ev.command_code == CMD_RIGHT) ? 16'(0 - turn) : turn;
              time_left       = dur[15:0];
              stop_sent       = 1'b0;
              res.detail_code = DET_ACCEPTED;
            end
          end
        end
        MODE_DISCONNECT: begin
          drop_motion();
          res.detail_code = status_code();
        end
        default: begin
          res.ok          = 1'b0;
          res.detail_code = DET_UNSUPPORTED;
        end
      endcase
      obs_ok             = obst_known && fresh();
      res.connected      = connected();
      res.obstacle_valid = obs_ok;
      res.obstacle_seen  = obs_ok && obst_flag;
      res.estop_active   = latched;
      res.nearest_mm     = obs_ok ? nearest : 16'd0;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Compare one result item against the oldest prediction
    task check_result(msi_out_t got);
      msi_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", got));
        return;
      end
      want = pending_results.pop_front();
      compare_field("ok", got.ok, want.ok);
      compare_field("detail_code", got.detail_code, want.detail_code);
      compare_field("connected", got.connected, want.connected);
      compare_field("obstacle_valid", got.obstacle_valid, want.obstacle_valid);
      compare_field("obstacle_seen", got.obstacle_seen, want.obstacle_seen);
      compare_field("estop_active", got.estop_active, want.estop_active);
      compare_field("nearest_mm", got.nearest_mm, want.nearest_mm);
      compare_field("drive_kind", got.drive_kind, want.drive_kind);
      compare_field("drive_linear", got.drive_linear, want.drive_linear);
      compare_field("drive_turn", got.drive_turn, want.drive_turn);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;

  msi_in_if  in_ch ();
  msi_out_if out_ch ();

  interlock_tracker tracker = new(PERIOD_MS_DEF);

  motion_safety_interlock_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels at each rising edge: inputs first, then results
  always @(posedge clk_i) begin
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) tracker.note_event(in_ch.item);
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) tracker.check_result(out_ch.item);
  end

  // Receiver: stall at random
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("FAIL motion_safety_interlock_unit");
    $finish;
  end

  // Offer one item, with a random gap first; return at the negedge after acceptance
  task automatic send_event(input msi_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= ev;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    tracker.set_limit(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_limits(input logic [15:0] stop, input logic [15:0] lin,
                              input logic [15:0] turn, input logic [15:0] dur,
                              input logic [15:0] tmo, input logic need_st,
                              input logic need_cl);
    write_reg(CFG_OBSTACLE_STOP, stop);
    write_reg(CFG_MAX_LINEAR, lin);
    write_reg(CFG_MAX_TURN, turn);
    write_reg(CFG_MAX_DURATION, dur);
    write_reg(CFG_STATE_TIMEOUT, tmo);
    write_reg(CFG_NEED_STATE, {15'd0, need_st});
    write_reg(CFG_NEED_CLEAR, {15'd0, need_cl});
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, then wait for every predicted result to come out
  task automatic drain_results();
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (tracker.pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (tracker.pending_results.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.pending_results.size()));
      tracker.pending_results.delete();
    end
  endtask

  function automatic msi_in_t blank_event(input mode_e m);
    msi_in_t ev;
    ev      = '0;
    ev.mode = m;
    return ev;
  endfunction

  // Obstacle reading: beyond the stop distance for a clear view, else anything
  function automatic logic [15:0] pick_range(input bit clear_view, input logic [15:0] stop);
    int lo;
    if (clear_view) begin
      lo = (stop < 16'd11) ? 11 : int'(stop) + 1;
      if (lo > 65535) lo = 65535;
      return 16'($urandom_range(65535, lo));
    end
    case ($urandom_range(3))
      0: return 16'($urandom_range(20));
      1: begin
        lo = int'(stop) - 2 + int'($urandom_range(4));
        if (lo < 0) lo = 0;
        if (lo > 65535) lo = 65535;
        return 16'(lo);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] speed_request(input int span, input logic [15:0] raw_val);
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v = int'($urandom_range(span));
      if ($urandom_range(1)) v = -v;
      return 16'(v);
    end
    if (pick < 80) return raw_val;
    return EDGE_SPEEDS[$urandom_range(4)];
  endfunction

  // Mostly well-formed traffic: ticks, range updates, status, arm and motion commands
  task automatic random_burst(input int unsigned count);
    msi_in_t      ev;
    logic [127:0] raw;
    int unsigned  pick;
    int           v;
    bit           clear_view;
    for (int unsigned n = 0; n < count; n++) begin
      raw  = {$urandom, $urandom, $urandom, $urandom};
      ev   = raw[$bits(msi_in_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 45) begin
        ev.mode = MODE_TICK;
      end else if (pick < 57) begin
        ev.mode    = MODE_RANGES;
        clear_view = ($urandom_range(99) < 70);
        ev.range_a = pick_range(clear_view, tracker.stop_mm);
        ev.range_b = pick_range(clear_view, tracker.stop_mm);
        ev.range_c = pick_range(clear_view, tracker.stop_mm);
        ev.range_d = pick_range(clear_view, tracker.stop_mm);
        if ($urandom_range(3) != 0) ev.range_valid = 4'hF;
      end else if (pick < 62) begin
        ev.mode = MODE_STATUS;
      end else if (pick < 70) begin
        ev.mode = MODE_ARM;
      end else if (pick < 92) begin
        ev.mode = MODE_COMMAND;
        pick    = $urandom_range(99);
        if (pick < 70) ev.command_code = 3'($urandom_range(CMD_RIGHT, CMD_FORWARD));
        else if (pick < 85) ev.command_code = $urandom_range(1) ? CMD_STOP : CMD_IDLE;
        else ev.command_code = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
        ev.emergency_flag = ($urandom_range(99) < 8);
        ev.linear_request = speed_request(2 * int'(tracker.lin_max), raw[15:0]);
        ev.turn_request   = speed_request(2 * int'(tracker.turn_max), raw[31:16]);
        pick = $urandom_range(99);
        if (pick < 50) begin
          v = int'($urandom_range(2 * int'(tracker.dur_max)));
          ev.duration_request = (v > 32767) ? raw[47:32] : 16'(v);
        end else if (pick < 80) begin
          ev.duration_request = 16'(int'($urandom_range(155)) - 5);
        end
      end else if (pick < 96) begin
        ev.mode = MODE_DISCONNECT;
      end
      send_event(ev);
    end
  endtask

  // Corner cases from reset: stale, latched, floor readings, clamps, odd codes
  task automatic directed_events();
    msi_in_t ev;
    send_event(blank_event(MODE_STATUS));
    send_event(blank_event(MODE_ARM));
    ev = blank_event(MODE_COMMAND);
    ev.command_code = CMD_FORWARD;
    send_event(ev);
    ev.linear_request = 16'sd200;
    send_event(ev);
    ev.mode = MODE_SPARE_A;
    send_event(ev);
    ev.mode = MODE_SPARE_B;
    send_event(ev);
    // floor reading ignored, reading at the stop distance counts as obstacle
    ev = blank_event(MODE_RANGES);
    ev.range_a     = 16'd10;
    ev.range_b     = 16'd11;
    ev.range_c     = 16'd450;
    ev.range_d     = 16'hFFFF;
    ev.range_valid = 4'hF;
    send_event(ev);
    ev.range_valid = 4'h0;
    send_event(ev);
    ev.range_a     = 16'd0;
    ev.range_b     = 16'd9;
    ev.range_c     = 16'd10;
    ev.range_d     = 16'd10;
    ev.range_valid = 4'hF;
    send_event(ev);
    ev.range_a     = 16'd451;
    ev.range_b     = 16'hFFFF;
    ev.range_c     = 16'd1000;
    ev.range_d     = 16'd2000;
    ev.range_valid = 4'b1010;
    send_event(ev);
    send_event(blank_event(MODE_ARM));
    // speed and duration clamps at both ends
    ev = blank_event(MODE_COMMAND);
    ev.command_code     = CMD_FORWARD;
    ev.linear_request   = 16'sh7FFF;
    ev.duration_request = 16'sh8000;
    send_event(ev);
    ev.command_code     = CMD_BACKWARD;
    ev.linear_request   = 16'sh8000;
    ev.duration_request = 16'sh7FFF;
    send_event(ev);
    ev.command_code = CMD_LEFT;
    ev.turn_request = 16'sd0;
    send_event(ev);
    ev.command_code     = CMD_RIGHT;
    ev.turn_request     = 16'shFFFF;
    ev.duration_request = 16'sd0;
    send_event(ev);
    send_event(blank_event(MODE_TICK));
    send_event(blank_event(MODE_TICK));
    send_event(blank_event(MODE_TICK));
    ev.command_code = CMD_IDLE;
    send_event(ev);
    // unsupported code is refused, but with the emergency flag it latches
    ev.command_code = CMD_SPARE_A;
    send_event(ev);
    ev.command_code   = CMD_SPARE_B;
    ev.emergency_flag = 1'b1;
    send_event(ev);
    send_event(blank_event(MODE_ARM));
    ev = blank_event(MODE_COMMAND);
    ev.command_code = CMD_STOP;
    send_event(ev);
    send_event(blank_event(MODE_DISCONNECT));
  endtask

  // Arm with fresh state, move, then tick until the state ages past its timeout
  task automatic stale_after_timeout();
    msi_in_t ev;
    ev = blank_event(MODE_RANGES);
    ev.range_a     = 16'd1000;
    ev.range_b     = 16'd1000;
    ev.range_c     = 16'd1000;
    ev.range_d     = 16'd1000;
    ev.range_valid = 4'hF;
    send_event(ev);
    send_event(blank_event(MODE_ARM));
    ev = blank_event(MODE_COMMAND);
    ev.command_code     = CMD_FORWARD;
    ev.linear_request   = 16'sd200;
    ev.duration_request = 16'sh7FFF;
    send_event(ev);
    for (int n = 0; n < 45; n++) send_event(blank_event(MODE_TICK));
    send_event(blank_event(MODE_STATUS));
    send_event(blank_event(MODE_DISCONNECT));
  endtask

  // Main sequence
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.item    = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    send_idle_pct = 18;
    recv_idle_pct = 50;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apply_limits(16'd450, 16'd500, 16'd1000, 16'd2000, 16'd1000, 1'b1, 1'b1);
    directed_events();
    random_burst(160);
    drain_results();

    // low extremes, with a duration ceiling under the floor
    apply_limits(16'd1, 16'd1, 16'd1, 16'd40, 16'd1, 1'b0, 1'b0);
    random_burst(160);
    drain_results();

    send_idle_pct = 50;
    recv_idle_pct = 18;
    apply_limits(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    random_burst(160);
    drain_results();

    apply_limits(16'($urandom_range(65535, 1)), 16'($urandom_range(32767, 1)),
                 16'($urandom_range(32767, 1)), 16'($urandom_range(65535, 100)),
                 16'($urandom_range(65535, 1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    random_burst(160);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_limits(16'd300, 16'd800, 16'd1500, 16'd100, 16'd50, 1'b1, 1'b1);
    random_burst(160);
    drain_results();

    apply_limits(16'd450, 16'd500, 16'd1000, 16'hFFFF, 16'd30, 1'b1, 1'b0);
    stale_after_timeout();
    drain_results();

    repeat (8) @(negedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS motion_safety_interlock_unit");
    end else begin
      $display("FAIL motion_safety_interlock_unit");
    end
    $finish;
  end

endmodule
